// File: hdl/qsed_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the quoted string escape decoder.
// No dependencies; imported by every module of the block.
package qsed_pkg;

  localparam int QSED_CMD_DEPTH = 4;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd1;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
  localparam logic [2:0] ERR_CODE_POINT = 3'd4;

  // command ops between front and back
  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;
  localparam logic [1:0] CMD_UTF8  = 2'd3;

  // source characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } qsed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } qsed_out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] val;
  } qsed_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qsed_fifo_stat_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } qsed_hex_t;

  function automatic qsed_hex_t hex_decode(input logic [7:0] c);
    qsed_hex_t h;
    h.valid  = 1'b1;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.nibble = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: hdl/qsed_front.sv
`timescale 1ns / 1ps
// Front end: accepts source bytes, tracks the literal's parse state and issues commands.
// Depends on qsed_pkg.
module qsed_front
  import qsed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  qsed_in_t  in_data,
  output logic      full,
  output logic      cmd_push,
  output qsed_cmd_t cmd_data,
  input  logic      cmd_full
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  logic [1:0]  mode_r, mode_nxt;
  logic        dq_r, dq_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] acc_new;
  logic [7:0]  c;
  logic [7:0]  closer;
  logic        accept;
  qsed_hex_t   hx;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign c      = in_data.in_byte;
  assign closer = dq_r ? CH_DQUOTE : CH_SQUOTE;
  assign hx     = hex_decode(c);

  always_comb begin
    acc_new = acc_r;
    case (seen_r)
      2'd0:    acc_new[15:12] = acc_r[15:12] | hx.nibble;
      2'd1:    acc_new[11:8]  = acc_r[11:8]  | hx.nibble;
      2'd2:    acc_new[7:4]   = acc_r[7:4]   | hx.nibble;
      default: acc_new[3:0]   = acc_r[3:0]   | hx.nibble;
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    dq_nxt       = dq_r;
    seen_nxt     = seen_r;
    acc_nxt      = acc_r;
    cmd_push     = 1'b0;
    cmd_data.op  = CMD_BYTE;
    cmd_data.val = {8'd0, c};
    if (accept) begin
      if (in_data.start_req) begin
        dq_nxt   = (c != CH_SQUOTE);
        mode_nxt = MODE_STR;
        seen_nxt = 2'd0;
        acc_nxt  = 16'd0;
      end else begin
        case (mode_r)
          MODE_STR: begin
            cmd_push = 1'b1;
            if (c == CH_NUL || c == CH_LF) begin
              mode_nxt     = MODE_IDLE;
              cmd_data.op  = CMD_ERROR;
              cmd_data.val = {13'd0, ERR_UNCLOSED};
            end else if (c == closer) begin
              mode_nxt    = MODE_IDLE;
              cmd_data.op = CMD_CLOSE;
            end else if (c == CH_BSLASH) begin
              mode_nxt = MODE_ESC;
              cmd_push = 1'b0;
            end
          end
          MODE_ESC: begin
            cmd_push = 1'b1;
            mode_nxt = MODE_STR;
            if (c == closer || c == CH_BSLASH) begin
              cmd_data.val = {8'd0, c};
            end else if (c == CH_NUL) begin
              mode_nxt     = MODE_IDLE;
              cmd_data.op  = CMD_ERROR;
              cmd_data.val = {13'd0, ERR_UNCLOSED};
            end else if (c == 8'h6E) begin
              cmd_data.val = 16'h000A;
            end else if (c == 8'h74) begin
              cmd_data.val = 16'h0009;
            end else if (c == 8'h62) begin
              cmd_data.val = 16'h0008;
            end else if (c == 8'h66) begin
              cmd_data.val = 16'h000C;
            end else if (c == 8'h72) begin
              cmd_data.val = 16'h000D;
            end else if (c == 8'h75) begin
              cmd_push = 1'b0;
              mode_nxt = MODE_HEX;
              seen_nxt = 2'd0;
              acc_nxt  = 16'd0;
            end else begin
              mode_nxt     = MODE_IDLE;
              cmd_data.op  = CMD_ERROR;
              cmd_data.val = {13'd0, ERR_BAD_ESCAPE};
            end
          end
          MODE_HEX: begin
            if (!hx.valid) begin
              cmd_push     = 1'b1;
              mode_nxt     = MODE_IDLE;
              cmd_data.op  = CMD_ERROR;
              cmd_data.val = {13'd0, ERR_BAD_HEX};
            end else if (seen_r != 2'd3) begin
              acc_nxt  = acc_new;
              seen_nxt = seen_r + 2'd1;
            end else begin
              seen_nxt = 2'd0;
              acc_nxt  = 16'd0;
              if (acc_new >= 16'hD800 && acc_new <= 16'hDFFF) begin
                cmd_push     = 1'b1;
                mode_nxt     = MODE_IDLE;
                cmd_data.op  = CMD_ERROR;
                cmd_data.val = {13'd0, ERR_CODE_POINT};
              end else begin
                mode_nxt     = MODE_STR;
                cmd_push     = (acc_new != 16'd0);
                cmd_data.op  = CMD_UTF8;
                cmd_data.val = acc_new;
              end
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dq_r   <= 1'b0;
      seen_r <= 2'd0;
      acc_r  <= 16'd0;
    end else begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// File: hdl/qsed_cmd_fifo.sv
`timescale 1ns / 1ps
// Command queue between the front end and the back end.
// Depends on qsed_pkg.
module qsed_cmd_fifo
  import qsed_pkg::*;
#(
  parameter int DEPTH = QSED_CMD_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  qsed_cmd_t       wr_data,
  input  logic            rd_en,
  output qsed_cmd_t       rd_data,
  output qsed_fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qsed_cmd_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FULL_CNT);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: hdl/qsed_back.sv
`timescale 1ns / 1ps
// Back end: expands queued commands into result transactions, UTF-8 encoding code points.
// Depends on qsed_pkg.
module qsed_back
  import qsed_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  qsed_cmd_t       cmd_data,
  input  qsed_fifo_stat_t cmd_stat,
  output logic            cmd_pop,
  output logic            empty,
  input  logic            pop,
  output qsed_out_t       out_data
);

  logic       out_valid_r;
  qsed_out_t  out_r, item;
  logic [1:0] idx_r;
  logic [1:0] nbytes;
  logic       load;
  logic [15:0] cp;

  assign empty    = !out_valid_r;
  assign out_data = out_r;
  assign load     = (!out_valid_r || pop) && !cmd_stat.empty;
  assign cp       = cmd_data.val;

  always_comb begin
    item.out_byte   = 8'd0;
    item.kind       = KIND_DATA;
    item.error_code = ERR_NONE;
    item.last       = 1'b1;
    nbytes          = 2'd1;
    case (cmd_data.op)
      CMD_BYTE: begin
        item.out_byte = cp[7:0];
      end
      CMD_CLOSE: begin
        item.kind = KIND_CLOSE;
      end
      CMD_ERROR: begin
        item.kind       = KIND_ERROR;
        item.error_code = cp[2:0];
      end
      CMD_UTF8: begin
        if (cp < 16'h0080) begin
          nbytes        = 2'd1;
          item.out_byte = cp[7:0];
        end else if (cp < 16'h0800) begin
          nbytes        = 2'd2;
          item.out_byte = (idx_r == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else begin
          nbytes = 2'd3;
          case (idx_r)
            2'd0:    item.out_byte = {4'b1110, cp[15:12]};
            2'd1:    item.out_byte = {2'b10, cp[11:6]};
            default: item.out_byte = {2'b10, cp[5:0]};
          endcase
        end
        item.last = (idx_r == nbytes - 2'd1);
      end
      default: begin
        item.kind = KIND_DATA;
      end
    endcase
  end

  assign cmd_pop = load && item.last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= item.last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/quoted_string_escape_decoder_unit.sv
`timescale 1ns / 1ps
// Quoted string literal escape decoder, top level: front end, command queue, back end.
// Depends on qsed_pkg, qsed_front, qsed_cmd_fifo, qsed_back.
//
// A byte with start_req set opens a string; following bytes come out as decoded content
// bytes, a close transaction, or an error transaction. The input side takes one byte per
// cycle while the command queue (CMD_DEPTH entries) has room; each byte that yields output
// costs one queue entry. The back end delivers one result per cycle while each result is
// popped; a \uXXXX escape of 0x80 or above yields two or three bytes; short runs of those
// are absorbed by the queue, longer runs lower input rate to the UTF-8 output rate.
// Output is registered: a result is held on out_data while empty is low until popped.
module quoted_string_escape_decoder_unit
  import qsed_pkg::*;
#(
  parameter int CMD_DEPTH = QSED_CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  qsed_in_t  in_data,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output qsed_out_t out_data
);

  logic            cmd_push, cmd_pop;
  qsed_cmd_t       cmd_wr, cmd_rd;
  qsed_fifo_stat_t cmd_stat;

  qsed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wr),
    .cmd_full (cmd_stat.full)
  );

  qsed_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .stat    (cmd_stat)
  );

  qsed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_data (cmd_rd),
    .cmd_stat (cmd_stat),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
